// ===== hw/rtl/occupancy_grid_fusion_macros.svh =====
`ifndef OCCUPANCY_GRID_FUSION_MACROS_SVH
`define OCCUPANCY_GRID_FUSION_MACROS_SVH

// same-cycle implication, checked outside reset
`define OGF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ogf check failed");

// next-cycle implication, checked outside reset
`define OGF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ogf check failed");

`endif

// ===== hw/rtl/ogf_pkg.sv =====
`timescale 1ns / 1ps

package ogf_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_RADIUS = 31;

  localparam int COORD_W  = 8;
  localparam int VALUE_W  = 8;
  localparam int DIM_W    = 9;
  localparam int THR_W    = 7;
  localparam int CRAD_W   = 5;
  localparam int CFG_W    = 9;
  localparam int CFG_IDX_W = 3;

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int D_W    = RAD_W + 1;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int NX_W   = ((COORD_W > RAD_W) ? COORD_W : RAD_W) + 2;

  localparam logic signed [VALUE_W-1:0] BLOCKED_VALUE = VALUE_W'(100);
  localparam logic [THR_W-1:0]          THRESHOLD_CAP = THR_W'(100);
  localparam logic [THR_W-1:0]          THRESHOLD_RST = THR_W'(80);

  typedef enum logic [1:0] {
    OP_BASE    = 2'd0,
    OP_OVERLAY = 2'd1,
    OP_DISC    = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_RANGE     = 2'd1,
    STAT_NOT_READY = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_THRESHOLD   = 3'd2,
    CFG_UNKNOWN_OBS = 3'd3,
    CFG_RADIUS      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RES_REJECT = 3'd0,
    RES_BASE   = 3'd1,
    RES_ZERO   = 3'd2,
    RES_RAM    = 3'd3,
    RES_ONE    = 3'd4
  } res_src_t;

  typedef struct packed {
    logic     take_item;
    logic     base_wr;
    logic     mark_wr;
    logic     rd_cell;
    logic     disc_init;
    logic     disc_step;
    logic     res_load;
    res_src_t res_src;
    logic     load_out;
  } ogf_cmd_t;

  typedef struct packed {
    op_t     op;
    status_t chk;
    logic    obstacle;
    logic    radius_zero;
    logic    disc_last;
  } ogf_sts_t;

endpackage

// ===== hw/rtl/ogf_ram.sv =====
`timescale 1ns / 1ps

module ogf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/ogf_ctrl.sv =====
`timescale 1ns / 1ps
`include "occupancy_grid_fusion_macros.svh"

module ogf_ctrl
  import ogf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  ogf_sts_t sts,
  output ogf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_WAIT_RD,
    S_DISC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.res_src   = RES_REJECT;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (sts.chk != STAT_OK) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_REJECT;
          state_nxt    = S_DONE;
        end else begin
          unique case (sts.op)
            OP_BASE: begin
              cmd.base_wr  = 1'b1;
              cmd.res_load = 1'b1;
              cmd.res_src  = RES_BASE;
              state_nxt    = S_DONE;
            end
            OP_OVERLAY: begin
              if (sts.obstacle) begin
                cmd.mark_wr  = 1'b1;
                cmd.res_load = 1'b1;
                cmd.res_src  = RES_ZERO;
                state_nxt    = S_DONE;
              end else begin
                cmd.rd_cell = 1'b1;
                state_nxt   = S_WAIT_RD;
              end
            end
            OP_DISC: begin
              if (sts.radius_zero) begin
                cmd.rd_cell = 1'b1;
                state_nxt   = S_WAIT_RD;
              end else begin
                cmd.disc_init = 1'b1;
                state_nxt     = S_DISC;
              end
            end
            OP_READ: begin
              cmd.rd_cell = 1'b1;
              state_nxt   = S_WAIT_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_WAIT_RD: begin
        cmd.res_load = 1'b1;
        cmd.res_src  = RES_RAM;
        state_nxt    = S_DONE;
      end
      S_DISC: begin
        cmd.disc_step = 1'b1;
        if (sts.disc_last) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RES_ONE;
          state_nxt    = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  `OGF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_r || out_tready)
  `OGF_ASSERT_NEXT(a_accept_to_lookup, in_tvalid && in_tready, state_r == S_LOOKUP)
  `OGF_ASSERT_NEXT(a_read_waits, cmd.rd_cell, state_r == S_WAIT_RD)
  `OGF_ASSERT_NEXT(a_disc_ends, (state_r == S_DISC) && sts.disc_last, state_r == S_DONE)

endmodule

// ===== hw/rtl/ogf_dp.sv =====
`timescale 1ns / 1ps
`include "occupancy_grid_fusion_macros.svh"

module ogf_dp
  import ogf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [1:0]           in_op,
  input  logic [COORD_W-1:0]   in_x,
  input  logic [COORD_W-1:0]   in_y,
  input  logic [VALUE_W-1:0]   in_value,
  input  ogf_cmd_t             cmd,
  output ogf_sts_t             sts,
  output logic                 out_free,
  output logic [1:0]           out_status
);

  logic [DIM_W-1:0]  grid_width_r, grid_height_r;
  logic [THR_W-1:0]  threshold_r;
  logic              unknown_obs_r;
  logic [CRAD_W-1:0] radius_r;

  op_t                        op_r;
  logic [COORD_W-1:0]         x_r, y_r;
  logic signed [VALUE_W-1:0]  value_r;

  logic signed [D_W-1:0] dx_r, dy_r;

  logic    res_free_r;
  status_t res_status_r;
  logic    out_free_r;
  status_t out_status_r;

  logic [DIM_W-1:0]      w_eff, h_eff;
  logic [THR_W-1:0]      thr_eff;
  logic [RAD_W-1:0]      r_eff;
  logic signed [D_W-1:0] r_pos, r_neg;
  status_t               chk;
  logic                  obstacle;
  logic                  base_bit;
  logic [ADDR_W-1:0]     item_addr;

  logic signed [NX_W-1:0] nx, ny;
  logic [RAD_W-1:0]       ax, ay;
  logic [SQ_W-1:0]        ax2, ay2, r2;
  logic [SQ_W:0]          dist_sq;
  logic                   nx_in, ny_in, disc_hit;
  logic [ADDR_W-1:0]      disc_addr;

  logic              ram_we, ram_wd, ram_rd;
  logic [ADDR_W-1:0] ram_wa;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= '0;
      grid_height_r <= '0;
      threshold_r   <= THRESHOLD_RST;
      unknown_obs_r <= 1'b0;
      radius_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_data[DIM_W-1:0];
        CFG_GRID_HEIGHT: grid_height_r <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:   threshold_r   <= cfg_data[THR_W-1:0];
        CFG_UNKNOWN_OBS: unknown_obs_r <= cfg_data[0];
        CFG_RADIUS:      radius_r      <= cfg_data[CRAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff   = (int'(grid_width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : grid_width_r;
    h_eff   = (int'(grid_height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : grid_height_r;
    thr_eff = (threshold_r > THRESHOLD_CAP) ? THRESHOLD_CAP : threshold_r;
    r_eff   = RAD_W'((int'(radius_r) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_r));
    r_pos   = signed'({1'b0, r_eff});
    r_neg   = -r_pos;

    if ((w_eff == '0) || (h_eff == '0)) begin
      chk = STAT_NOT_READY;
    end else if (({1'b0, x_r} >= w_eff) || ({1'b0, y_r} >= h_eff)) begin
      chk = STAT_RANGE;
    end else begin
      chk = STAT_OK;
    end

    if (value_r[VALUE_W-1]) begin
      obstacle = unknown_obs_r;
    end else begin
      obstacle = (value_r[THR_W-1:0] >= thr_eff);
    end
    base_bit  = (value_r != BLOCKED_VALUE);
    item_addr = ADDR_W'(y_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_r);
  end

  // disc geometry for the current offset
  always_comb begin
    nx        = $signed({{(NX_W-COORD_W){1'b0}}, x_r}) + NX_W'(dx_r);
    ny        = $signed({{(NX_W-COORD_W){1'b0}}, y_r}) + NX_W'(dy_r);
    ax        = RAD_W'(dx_r[D_W-1] ? -dx_r : dx_r);
    ay        = RAD_W'(dy_r[D_W-1] ? -dy_r : dy_r);
    ax2       = ax * ax;
    ay2       = ay * ay;
    r2        = r_eff * r_eff;
    dist_sq   = {1'b0, ax2} + {1'b0, ay2};
    nx_in     = !nx[NX_W-1] && (nx < $signed({{(NX_W-DIM_W){1'b0}}, w_eff}));
    ny_in     = !ny[NX_W-1] && (ny < $signed({{(NX_W-DIM_W){1'b0}}, h_eff}));
    disc_hit  = nx_in && ny_in && (dist_sq <= {1'b0, r2});
    disc_addr = ADDR_W'(ny) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nx);
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_r    <= op_t'(in_op);
      x_r     <= in_x;
      y_r     <= in_y;
      value_r <= in_value;
    end
    if (cmd.disc_init) begin
      dx_r <= r_neg;
      dy_r <= r_neg;
    end else if (cmd.disc_step) begin
      if (dx_r == r_pos) begin
        dx_r <= r_neg;
        dy_r <= dy_r + D_W'(1);
      end else begin
        dx_r <= dx_r + D_W'(1);
      end
    end
    if (cmd.res_load) begin
      case (cmd.res_src)
        RES_REJECT: begin
          res_free_r   <= 1'b0;
          res_status_r <= chk;
        end
        RES_BASE: begin
          res_free_r   <= base_bit;
          res_status_r <= STAT_OK;
        end
        RES_ZERO: begin
          res_free_r   <= 1'b0;
          res_status_r <= STAT_OK;
        end
        RES_RAM: begin
          res_free_r   <= ram_rd;
          res_status_r <= STAT_OK;
        end
        default: begin
          res_free_r   <= 1'b1;
          res_status_r <= STAT_OK;
        end
      endcase
    end
    if (cmd.load_out) begin
      out_free_r   <= res_free_r;
      out_status_r <= res_status_r;
    end
  end

  assign ram_we = cmd.base_wr || cmd.mark_wr || (cmd.disc_step && disc_hit);
  assign ram_wd = cmd.base_wr ? base_bit : !cmd.mark_wr;
  assign ram_wa = cmd.disc_step ? disc_addr : item_addr;

  ogf_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (cmd.rd_cell),
    .rd_addr (item_addr),
    .rd_data (ram_rd)
  );

  assign sts.op          = op_r;
  assign sts.chk         = chk;
  assign sts.obstacle    = obstacle;
  assign sts.radius_zero = (r_eff == '0);
  assign sts.disc_last   = (dx_r == r_pos) && (dy_r == r_pos);

  assign out_free   = out_free_r;
  assign out_status = out_status_r;

  `OGF_ASSERT_NOW(a_no_rd_wr_clash, ram_we, !cmd.rd_cell)
  `OGF_ASSERT_NOW(a_disc_in_grid, cmd.disc_step && disc_hit, nx_in && ny_in && (chk == STAT_OK))

endmodule

// ===== hw/rtl/occupancy_grid_fusion.sv =====
// sequence: base writes, obstacle marks and rejected items go through the LOOKUP and DONE states,
//   reads add WAIT_RD (registered map read port); DONE holds until the output slot is free
// flow: one item at a time, a new input is taken only in IDLE; a disc clear of radius r steps
//   through (2r+1)^2 offsets, one cell per cycle through the single map write port
// synchronous active-low reset clears control and config (threshold 80); map is undefined until written
`timescale 1ns / 1ps

module occupancy_grid_fusion
  import ogf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // cell_x, cell_y, cell_value
  input  logic [1:0]           in_tuser,   // operation
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // cell_free, zero fill
  output logic [1:0]           out_tuser   // status
);

  ogf_cmd_t cmd;
  ogf_sts_t sts;
  logic     out_free;

  ogf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ogf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_op      (in_tuser),
    .in_x       (in_tdata[7:0]),
    .in_y       (in_tdata[15:8]),
    .in_value   (in_tdata[23:16]),
    .cmd        (cmd),
    .sts        (sts),
    .out_free   (out_free),
    .out_status (out_tuser)
  );

  assign out_tdata = {7'b0, out_free};

endmodule
